/* rtl/cbli_pkg.sv */
// Package for the current-based leaky integrator: item types, opcodes,
// store sizing and the Q15 saturating helper. No dependencies.
package cbli_pkg;

  localparam int unsigned NEURONS = 256;
  localparam int unsigned ADDR_W  = (NEURONS > 1) ? $clog2(NEURONS) : 1;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;

  typedef struct packed {
    logic        [1:0]  opcode;
    logic        [7:0]  neuron_index;
    logic signed [31:0] value;
    logic        [31:0] current_decay_factor;
    logic signed [31:0] input_weight;
    logic        [31:0] output_decay_factor;
    logic signed [31:0] resistance;
    logic signed [31:0] initial_output;
  } in_item_t;

  typedef struct packed {
    logic        [7:0]  out_neuron;
    logic signed [31:0] output_value;
    logic signed [31:0] current_value;
  } out_item_t;

  // floor(p / 2^15), clamped to the signed 32-bit range
  function automatic logic [31:0] sat_q15(input logic [63:0] p);
    logic [48:0] s;
    logic [31:0] r;
    s = p[63:15];
    if (!s[48] && (|s[47:31])) begin
      r = 32'h7FFF_FFFF;
    end else if (s[48] && !(&s[47:31])) begin
      r = 32'h8000_0000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/current_based_leaky_integrator.sv */
// Current-based leaky integrator: per-neuron stores and a sequencer around
// one shared 33x33 signed multiplier. Depends on cbli_pkg.
//
// Channel  | Dir | Handshake            | Payload
// ---------+-----+----------------------+------------------------------
// in_      | in  | in_valid / in_ready  | in_data     (in_item_t)
// out_     | out | out_valid / out_ready| out_payload (out_item_t)
//
// Steps: a load is written as it is accepted, an add reads, then writes back the
// accumulator, and an update reads, then runs four multiplications in turn on
// the one multiplier, each registered before the next step uses it.
// Reset clears the sequencer and the output valid flag; a clearing pass then
// writes zero to every store entry, one entry per cycle, with the input held
// off. A finished update waits in its last step while the output register is
// still full; loads and adds are not held by a stall.
module current_based_leaky_integrator
  import cbli_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_payload
);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_RD,
    S_M1,
    S_M2,
    S_M3,
    S_M4
  } state_t;

  state_t state_r, state_nxt;

  // Per-item registers
  logic [1:0]        op_r;
  logic [ADDR_W-1:0] addr_r;
  logic [7:0]        idx_r;
  logic [31:0]       val_r;
  logic [63:0]       prod_r;
  logic [31:0]       sum_r;
  logic [31:0]       cur_r;
  logic              out_valid_r;
  out_item_t         out_payload_r;
  logic [ADDR_W-1:0] clr_addr_r;

  // Stores: parameters {res, od, w, cd}, state {output, current}, accumulator
  logic [127:0] par_mem [NEURONS];
  logic [63:0]  st_mem  [NEURONS];
  logic [31:0]  acc_mem [NEURONS];

  logic [127:0] par_rd_r;
  logic [63:0]  st_rd_r;
  logic [31:0]  acc_rd_r;

  logic              accept;
  logic              in_ok;
  logic [ADDR_W-1:0] in_addr;
  logic              fin;
  logic              clearing;
  logic              load_we;

  logic [31:0] cur_q, out_q, acc_q, cd_q, w_q, od_q, res_q;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic               mul_en;
  logic [31:0]        sat_prod, dec_prod, sum_new;

  logic              par_we, st_we, acc_we;
  logic [ADDR_W-1:0] par_wa, st_wa, acc_wa;
  logic [127:0]      par_wd;
  logic [63:0]       st_wd;
  logic [31:0]       acc_wd;

  assign in_ready    = (state_r == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign in_ok       = (32'(in_data.neuron_index) < NEURONS);
  assign in_addr     = ADDR_W'(in_data.neuron_index);
  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;
  assign clearing    = (state_r == S_CLR);

  // Finish an update only once the output register can take the result
  assign fin = (state_r == S_M4) && (!out_valid_r || out_ready);

  // Split the registered read words into fields
  assign cur_q = st_rd_r[31:0];
  assign out_q = st_rd_r[63:32];
  assign acc_q = acc_rd_r;
  assign cd_q  = par_rd_r[31:0];
  assign w_q   = par_rd_r[63:32];
  assign od_q  = par_rd_r[95:64];
  assign res_q = par_rd_r[127:96];

  // Operand select for the shared multiplier; decay factors are unsigned
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      S_RD: begin
        mul_a = {cur_q[31], cur_q};
        mul_b = {1'b0, cd_q};
      end
      S_M1: begin
        mul_a = {acc_q[31], acc_q};
        mul_b = {w_q[31], w_q};
      end
      S_M2: begin
        mul_a = {out_q[31], out_q};
        mul_b = {1'b0, od_q};
      end
      S_M3: begin
        mul_a = {cur_r[31], cur_r};
        mul_b = {res_q[31], res_q};
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign dec_prod = prod_r[63:32];
  assign sat_prod = sat_q15(prod_r);
  // Wrapping add of the held decay term and the saturated product
  assign sum_new  = sum_r + sat_prod;

  // Store write ports; the clearing pass takes all three
  always_comb begin
    load_we = accept && in_ok && (in_data.opcode == OP_LOAD);

    par_we = 1'b0;
    par_wa = in_addr;
    par_wd = {in_data.resistance, in_data.output_decay_factor,
              in_data.input_weight, in_data.current_decay_factor};
    if (clearing) begin
      par_we = 1'b1;
      par_wa = clr_addr_r;
      par_wd = '0;
    end else if (load_we) begin
      par_we = 1'b1;
    end

    st_we = 1'b0;
    st_wa = in_addr;
    st_wd = {in_data.initial_output, in_data.value};
    if (clearing) begin
      st_we = 1'b1;
      st_wa = clr_addr_r;
      st_wd = '0;
    end else if (load_we) begin
      st_we = 1'b1;
    end else if (fin) begin
      st_we = 1'b1;
      st_wa = addr_r;
      st_wd = {sum_new, cur_r};
    end

    acc_we = 1'b0;
    acc_wa = addr_r;
    acc_wd = '0;
    if (clearing) begin
      acc_we = 1'b1;
      acc_wa = clr_addr_r;
    end else if ((state_r == S_RD) && (op_r == OP_ADD)) begin
      acc_we = 1'b1;
      acc_wd = acc_q + val_r;
    end else if (fin) begin
      acc_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (par_we) begin
      par_mem[par_wa] <= par_wd;
    end
    if (state_r == S_IDLE) begin
      par_rd_r <= par_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_wa] <= st_wd;
    end
    if (state_r == S_IDLE) begin
      st_rd_r <= st_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_wa] <= acc_wd;
    end
    if (state_r == S_IDLE) begin
      acc_rd_r <= acc_mem[in_addr];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        if (clr_addr_r == ADDR_W'(NEURONS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept && in_ok &&
            ((in_data.opcode == OP_ADD) || (in_data.opcode == OP_UPDATE))) begin
          state_nxt = S_RD;
        end
      end
      S_RD:    state_nxt = (op_r == OP_ADD) ? S_IDLE : S_M1;
      S_M1:    state_nxt = S_M2;
      S_M2:    state_nxt = S_M3;
      S_M3:    state_nxt = S_M4;
      S_M4:    state_nxt = fin ? S_IDLE : S_M4;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Advance the clearing address one entry per cycle
      if (clearing) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end

    // Capture the item
    if (accept) begin
      op_r   <= in_data.opcode;
      addr_r <= in_addr;
      idx_r  <= in_data.neuron_index;
      val_r  <= in_data.value;
    end

    // One multiplication per step, registered before use
    if (mul_en) begin
      prod_r <= mul_p[63:0];
    end

    // Hold the decay term while the next product forms
    if ((state_r == S_M1) || (state_r == S_M3)) begin
      sum_r <= dec_prod;
    end

    // New current, needed again for the output step and the result
    if (state_r == S_M2) begin
      cur_r <= sum_new;
    end

    if (fin) begin
      out_payload_r.out_neuron    <= idx_r;
      out_payload_r.output_value  <= sum_new;
      out_payload_r.current_value <= cur_r;
    end
  end

endmodule
